[rtl/core/fsls_pkg.sv]
// ----------------------------------------------------------------------------
// fsls_pkg
// Shared types, sizes and constants of the flow statistics learning switch.
// ----------------------------------------------------------------------------
package fsls_pkg;

  localparam int FLOW_ENTRIES = 256;
  localparam int MAC_ENTRIES  = 256;
  localparam int FLOW_AW = $clog2(FLOW_ENTRIES);
  localparam int FLOW_CW = $clog2(FLOW_ENTRIES + 1);
  localparam int MAC_AW  = $clog2(MAC_ENTRIES);
  localparam int MAC_CW  = $clog2(MAC_ENTRIES + 1);

  localparam logic [15:0] IPV4_TYPE = 16'h0800;
  localparam int UNIT_SHIFT = 6;
  localparam int GROUP_BIT  = 40;

  localparam int IN_W  = 272;
  localparam int OUT_W = 152;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] packets;
    logic [31:0] units;
    logic [61:0] first_ts;
    logic [61:0] last_ts;
  } flow_entry_t;

  typedef struct packed {
    logic [47:0] address;
    logic [15:0] port;
  } mac_entry_t;

  localparam int FLOW_W = $bits(flow_entry_t);
  localparam int MAC_W  = $bits(mac_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRD,
    ST_FCMP,
    ST_FWR,
    ST_SRD,
    ST_SCMP,
    ST_SWR,
    ST_DRD,
    ST_DCMP,
    ST_DONE
  } state_e;

endpackage

[rtl/core/flow_stats_learning_switch_top.sv]
// ----------------------------------------------------------------------------
// flow_stats_learning_switch_top
// Flow counter table and MAC learning table behind one header stream.
// ----------------------------------------------------------------------------
// One header word enters on s_axis and yields one result word on m_axis.
// Both tables are filled from entry 0 upward and never freed, so each keeps
// a fill count and is searched linearly through its single-port RAM, one
// entry at a time (read, compare). Non-IPv4 words skip the flow scan,
// group source MACs skip learning.
// Reset clears the fill counts and the control state; RAM contents need no
// clearing. A new word is taken as soon as the previous one has finished its
// scans, even while its result still waits; a stalled receiver holds the
// block in its final state until the output register frees up.
// ----------------------------------------------------------------------------
module flow_stats_learning_switch_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // ether_type, src_ip, dst_ip, frame_length, time_sec, time_nsec,
  // ingress_port, src_mac, dst_mac
  input  logic [fsls_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // egress_port, flood, flow_updated, flow_dropped, flow_packets,
  // flow_units, first_sec, first_nsec
  output logic [fsls_pkg::OUT_W-1:0] m_axis_tdata_o
);

  fsls_pkg::state_e state_q, state_d;

  logic [fsls_pkg::IN_W-1:0] in_q;
  logic [15:0] ether_type;
  logic [31:0] src_ip, dst_ip, time_sec;
  logic [15:0] frame_length, ingress_port;
  logic [29:0] time_nsec;
  logic [47:0] src_mac, dst_mac;

  assign ether_type   = in_q[15:0];
  assign src_ip       = in_q[47:16];
  assign dst_ip       = in_q[79:48];
  assign frame_length = in_q[95:80];
  assign time_sec     = in_q[127:96];
  assign time_nsec    = in_q[157:128];
  assign ingress_port = in_q[173:158];
  assign src_mac      = in_q[221:174];
  assign dst_mac      = in_q[269:222];

  logic        is_ipv4, src_group, dst_group;
  logic [63:0] key;
  logic [61:0] now;
  logic [31:0] units;

  assign is_ipv4   = (ether_type == fsls_pkg::IPV4_TYPE);
  assign src_group = src_mac[fsls_pkg::GROUP_BIT];
  assign dst_group = dst_mac[fsls_pkg::GROUP_BIT];
  assign key       = (src_ip < dst_ip) ? {src_ip, dst_ip} : {dst_ip, src_ip};
  assign now       = {time_sec, time_nsec};
  assign units     = {22'd0, frame_length[15:fsls_pkg::UNIT_SHIFT]};

  logic [fsls_pkg::FLOW_CW-1:0] fcount_q, fidx_q;
  logic [fsls_pkg::MAC_CW-1:0]  mcount_q, midx_q;
  logic fhit, ffull, mhit, mfull;

  assign fhit  = (fidx_q != fcount_q);
  assign ffull = (fcount_q == fsls_pkg::FLOW_CW'(fsls_pkg::FLOW_ENTRIES));
  assign mhit  = (midx_q != mcount_q);
  assign mfull = (mcount_q == fsls_pkg::MAC_CW'(fsls_pkg::MAC_ENTRIES));

  logic                    f_we, f_re, m_we, m_re;
  fsls_pkg::flow_entry_t   f_wdata, f_rdata;
  fsls_pkg::mac_entry_t    m_wdata, m_rdata;
  logic [fsls_pkg::MAC_AW-1:0] m_addr;
  logic [fsls_pkg::FLOW_W-1:0] f_rraw;
  logic [fsls_pkg::MAC_W-1:0]  m_rraw;

  assign f_rdata = fsls_pkg::flow_entry_t'(f_rraw);
  assign m_rdata = fsls_pkg::mac_entry_t'(m_rraw);

  fsls_ram #(.WIDTH(fsls_pkg::FLOW_W), .DEPTH(fsls_pkg::FLOW_ENTRIES)) u_flow_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .re_i   (f_re),
    .addr_i (fidx_q[fsls_pkg::FLOW_AW-1:0]),
    .wdata_i(f_wdata),
    .rdata_o(f_rraw)
  );

  fsls_ram #(.WIDTH(fsls_pkg::MAC_W), .DEPTH(fsls_pkg::MAC_ENTRIES)) u_mac_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .re_i   (m_re),
    .addr_i (m_addr),
    .wdata_i(m_wdata),
    .rdata_o(m_rraw)
  );

  logic [15:0] egress_q;
  logic        flood_q, updated_q, dropped_q;
  logic [31:0] pk_q, un_q, fs_q;
  logic [29:0] fn_q;
  logic        out_valid_q;
  logic [fsls_pkg::OUT_W-1:0] out_data_q;
  logic        out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsls_pkg::ST_IDLE: if (s_axis_tvalid_i) state_d = fsls_pkg::ST_FRD;
      fsls_pkg::ST_FRD: begin
        if (!is_ipv4) begin
          state_d = src_group ? fsls_pkg::ST_DRD : fsls_pkg::ST_SRD;
        end else if (!fhit) begin
          state_d = fsls_pkg::ST_FWR;
        end else begin
          state_d = fsls_pkg::ST_FCMP;
        end
      end
      fsls_pkg::ST_FCMP: begin
        state_d = (f_rdata.key == key) ? fsls_pkg::ST_FWR : fsls_pkg::ST_FRD;
      end
      fsls_pkg::ST_FWR: state_d = src_group ? fsls_pkg::ST_DRD : fsls_pkg::ST_SRD;
      fsls_pkg::ST_SRD: state_d = mhit ? fsls_pkg::ST_SCMP : fsls_pkg::ST_SWR;
      fsls_pkg::ST_SCMP: begin
        state_d = (m_rdata.address == src_mac) ? fsls_pkg::ST_SWR : fsls_pkg::ST_SRD;
      end
      fsls_pkg::ST_SWR: state_d = fsls_pkg::ST_DRD;
      fsls_pkg::ST_DRD: begin
        state_d = (dst_group || !mhit) ? fsls_pkg::ST_DONE : fsls_pkg::ST_DCMP;
      end
      fsls_pkg::ST_DCMP: begin
        state_d = (m_rdata.address == dst_mac) ? fsls_pkg::ST_DONE : fsls_pkg::ST_DRD;
      end
      fsls_pkg::ST_DONE: if (out_free) state_d = fsls_pkg::ST_IDLE;
      default: state_d = fsls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    f_we    = 1'b0;
    f_re    = 1'b0;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_addr  = midx_q[fsls_pkg::MAC_AW-1:0];
    f_wdata = f_rdata;
    m_wdata = '{address: src_mac, port: ingress_port};
    unique case (state_q)
      fsls_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      fsls_pkg::ST_FRD:  f_re = is_ipv4 && fhit;
      fsls_pkg::ST_FWR: begin
        if (fhit) begin
          f_we = 1'b1;
          f_wdata.packets = f_rdata.packets + 32'd1;
          f_wdata.units   = f_rdata.units + units;
          f_wdata.last_ts = now;
        end else begin
          f_we = !ffull;
          f_wdata = '{key: key, packets: 32'd1, units: units,
                      first_ts: now, last_ts: now};
        end
      end
      fsls_pkg::ST_SRD: m_re = mhit;
      fsls_pkg::ST_SWR: begin
        if (mhit) begin
          m_we = 1'b1;
        end else begin
          m_we   = !mfull;
          m_addr = mcount_q[fsls_pkg::MAC_AW-1:0];
        end
      end
      fsls_pkg::ST_DRD: m_re = !dst_group && mhit;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsls_pkg::ST_IDLE;
      fcount_q    <= '0;
      mcount_q    <= '0;
      fidx_q      <= '0;
      midx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fsls_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        fsls_pkg::ST_IDLE: begin
          fidx_q <= '0;
          midx_q <= '0;
        end
        fsls_pkg::ST_FCMP: if (f_rdata.key != key) fidx_q <= fidx_q + 1'b1;
        fsls_pkg::ST_FWR:  if (!fhit && !ffull) fcount_q <= fcount_q + 1'b1;
        fsls_pkg::ST_SCMP: if (m_rdata.address != src_mac) midx_q <= midx_q + 1'b1;
        fsls_pkg::ST_SWR: begin
          midx_q <= '0;
          if (!mhit && !mfull) mcount_q <= mcount_q + 1'b1;
        end
        fsls_pkg::ST_DCMP: if (m_rdata.address != dst_mac) midx_q <= midx_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fsls_pkg::ST_IDLE: begin
        in_q      <= s_axis_tdata_i;
        egress_q  <= '0;
        flood_q   <= 1'b0;
        updated_q <= 1'b0;
        dropped_q <= 1'b0;
        pk_q      <= '0;
        un_q      <= '0;
        fs_q      <= '0;
        fn_q      <= '0;
      end
      fsls_pkg::ST_FWR: begin
        if (fhit) begin
          updated_q <= 1'b1;
          pk_q <= f_rdata.packets + 32'd1;
          un_q <= f_rdata.units + units;
          fs_q <= f_rdata.first_ts[61:30];
          fn_q <= f_rdata.first_ts[29:0];
        end else if (ffull) begin
          dropped_q <= 1'b1;
        end else begin
          updated_q <= 1'b1;
          pk_q <= 32'd1;
          un_q <= units;
          fs_q <= time_sec;
          fn_q <= time_nsec;
        end
      end
      fsls_pkg::ST_DRD: if (dst_group || !mhit) flood_q <= 1'b1;
      fsls_pkg::ST_DCMP: if (m_rdata.address == dst_mac) egress_q <= m_rdata.port;
      fsls_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_q <= {7'd0, fn_q, fs_q, un_q, pk_q, dropped_q, updated_q,
                         flood_q, egress_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[rtl/core/fsls_ram.sv]
// ----------------------------------------------------------------------------
// fsls_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fsls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fsls_checker.sv]
// ----------------------------------------------------------------------------
// fsls_checker
// Port-level checks of the flow statistics learning switch.
// ----------------------------------------------------------------------------
module fsls_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [fsls_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [fsls_pkg::OUT_W-1:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_flood: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[16] |-> m_axis_tdata_o[15:0] == 16'd0)
    else $error("flooded word carries a port");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[17] && m_axis_tdata_o[18]))
    else $error("flow updated and dropped together");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[17] |-> m_axis_tdata_o[151:19] == '0)
    else $error("flow fields set without update");

endmodule

bind flow_stats_learning_switch_top fsls_checker u_fsls_checker (.*);

[sim/flow_stats_learning_switch_top_tb.sv]
// ----------------------------------------------------------------------------
// flow_stats_learning_switch_top_tb
// Self-checking bench for the flow counter and MAC learning switch.
// ----------------------------------------------------------------------------
// Header words go in on s_axis and result words are checked on m_axis against
// a local model of both tables. The tests are directed corner cases, random
// traffic drawn from small address pools, a long receiver hold-off, and
// filling both tables past capacity. Random idle bursts on both sides stop
// for the final traffic phase.
// ----------------------------------------------------------------------------
module flow_stats_learning_switch_top_tb;

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ingress_port;
    logic [29:0] time_nsec;
    logic [31:0] time_sec;
    logic [15:0] frame_length;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [15:0] ether_type;
  } header_t;

  typedef struct packed {
    logic [29:0] first_nsec;
    logic [31:0] first_sec;
    logic [31:0] flow_units;
    logic [31:0] flow_packets;
    logic        flow_dropped;
    logic        flow_updated;
    logic        flood;
    logic [15:0] egress_port;
  } verdict_t;

  localparam int HDR_W = $bits(header_t);
  localparam int VRD_W = $bits(verdict_t);
  localparam int DRAIN_CYCLES = 2000;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [fsls_pkg::IN_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [fsls_pkg::OUT_W-1:0] m_axis_tdata_o;

  flow_stats_learning_switch_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  logic        fl_valid [fsls_pkg::FLOW_ENTRIES];
  logic [63:0] fl_key [fsls_pkg::FLOW_ENTRIES];
  logic [31:0] fl_packets [fsls_pkg::FLOW_ENTRIES];
  logic [31:0] fl_units [fsls_pkg::FLOW_ENTRIES];
  logic [61:0] fl_first [fsls_pkg::FLOW_ENTRIES];
  logic [61:0] fl_last [fsls_pkg::FLOW_ENTRIES];
  logic        mc_valid [fsls_pkg::MAC_ENTRIES];
  logic [47:0] mc_addr [fsls_pkg::MAC_ENTRIES];
  logic [15:0] mc_port [fsls_pkg::MAC_ENTRIES];

  verdict_t pending_verdicts[$];
  int mismatches;
  int failures;
  bit idle_en;
  bit hold_req;
  int hold_len;
  logic [31:0] ip_pool [16];
  logic [47:0] mac_pool [16];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic verdict_t switch_frame(input header_t h);
    verdict_t v;
    logic [63:0] key;
    int idx;
    int spare;
    v = '0;
    if (h.ether_type == fsls_pkg::IPV4_TYPE) begin
      key = (h.src_ip < h.dst_ip) ? {h.src_ip, h.dst_ip} : {h.dst_ip, h.src_ip};
      idx = -1;
      spare = -1;
      for (int i = 0; i < fsls_pkg::FLOW_ENTRIES; i++) begin
        if (fl_valid[i]) begin
          if (idx < 0 && fl_key[i] == key) idx = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (idx < 0 && spare < 0) begin
        v.flow_dropped = 1'b1;
      end else begin
        if (idx < 0) begin
          idx = spare;
          fl_valid[idx] = 1'b1;
          fl_key[idx] = key;
          fl_packets[idx] = 32'd1;
          fl_units[idx] = 32'(h.frame_length >> fsls_pkg::UNIT_SHIFT);
          fl_first[idx] = {h.time_sec, h.time_nsec};
        end else begin
          fl_packets[idx] = fl_packets[idx] + 32'd1;
          fl_units[idx] = fl_units[idx] + 32'(h.frame_length >> fsls_pkg::UNIT_SHIFT);
        end
        fl_last[idx] = {h.time_sec, h.time_nsec};
        v.flow_updated = 1'b1;
        v.flow_packets = fl_packets[idx];
        v.flow_units = fl_units[idx];
        v.first_sec = fl_first[idx][61:30];
        v.first_nsec = fl_first[idx][29:0];
      end
    end
    if (!h.src_mac[fsls_pkg::GROUP_BIT]) begin
      idx = -1;
      spare = -1;
      for (int i = 0; i < fsls_pkg::MAC_ENTRIES; i++) begin
        if (mc_valid[i]) begin
          if (idx < 0 && mc_addr[i] == h.src_mac) idx = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (idx < 0 && spare >= 0) begin
        idx = spare;
        mc_valid[idx] = 1'b1;
        mc_addr[idx] = h.src_mac;
      end
      if (idx >= 0) mc_port[idx] = h.ingress_port;
    end
    v.flood = 1'b1;
    if (!h.dst_mac[fsls_pkg::GROUP_BIT]) begin
      for (int i = 0; i < fsls_pkg::MAC_ENTRIES; i++) begin
        if (v.flood && mc_valid[i] && mc_addr[i] == h.dst_mac) begin
          v.flood = 1'b0;
          v.egress_port = mc_port[i];
        end
      end
    end
    return v;
  endfunction

  task automatic send_header(input header_t h);
    if (idle_en && $urandom_range(3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tdata_i = {{(fsls_pkg::IN_W - HDR_W){1'b0}}, h};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_verdicts.push_back(switch_frame(h));
    @(negedge clk_i);
  endtask

  function automatic header_t make_header(input logic [15:0] et, input logic [31:0] sip,
                                          input logic [31:0] dip, input logic [15:0] len,
                                          input logic [15:0] port, input logic [47:0] smac,
                                          input logic [47:0] dmac);
    header_t h;
    h.ether_type = et;
    h.src_ip = sip;
    h.dst_ip = dip;
    h.frame_length = len;
    h.time_sec = $urandom;
    h.time_nsec = 30'($urandom);
    h.ingress_port = port;
    h.src_mac = smac;
    h.dst_mac = dmac;
    return h;
  endfunction

  function automatic logic [47:0] pick_mac();
    logic [47:0] m;
    if ($urandom_range(9) == 0) begin
      m = 48'({$urandom, $urandom});
    end else begin
      m = mac_pool[$urandom_range(15)];
    end
    return m;
  endfunction

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(15)];
  endfunction

  // always @(posedge) checker: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[VRD_W-1:0];
      if (pending_verdicts.size() == 0) begin
        failures++;
        $display("unexpected result word %h", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: egress %h/%h flood %b/%b upd %b/%b drop %b/%b",
                      " pk %h/%h un %h/%h fs %h/%h fn %h/%h"},
                     want.egress_port, got.egress_port, want.flood, got.flood,
                     want.flow_updated, got.flow_updated, want.flow_dropped, got.flow_dropped,
                     want.flow_packets, got.flow_packets, want.flow_units, got.flow_units,
                     want.first_sec, got.first_sec, want.first_nsec, got.first_nsec);
        end
      end
    end
  end

  initial begin
    int held;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i = 1'b0;
        held = 0;
        while (held < hold_len) begin
          @(negedge clk_i);
          held++;
        end
        hold_req = 1'b0;
        m_axis_tready_i = 1'b1;
      end else if (idle_en && $urandom_range(3) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  task automatic test_directed();
    logic [47:0] ma;
    logic [47:0] mb;
    logic [47:0] grp;
    ma = 48'h0200_0000_0001;
    mb = 48'h0200_0000_0002;
    grp = 48'h0100_5E00_0001;
    send_header(make_header(16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 48'h0, 48'h0));
    send_header(make_header(16'hFFFF, '1, '1, '1, '1, '1, '1));
    send_header(make_header(16'h0008, 32'h1, 32'h2, 16'd64, 16'h1, ma, mb));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h0A00_0001, 32'h0A00_0002, 16'd63,
                            16'h0001, ma, mb));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h0A00_0002, 32'h0A00_0001, 16'd64,
                            16'h0002, mb, ma));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h0A00_0001, 32'h0A00_0002, 16'hFFFF,
                            16'hFFFF, ma, mb));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h7, 32'h7, 16'd0, 16'h0003, ma, ma));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h7, 32'h7, 16'd128, 16'h0004, ma, ma));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'hFFFF_FFFF, 32'h0, 16'd1000, 16'h0005,
                            grp, ma));
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h0, 32'hFFFF_FFFF, 16'd1000, 16'h0006,
                            mb, grp));
    send_header(make_header(16'h86DD, 32'h1, 32'h2, 16'd200, 16'h0007, 48'h0, 48'h0));
    send_header(make_header(16'h0806, 32'h1, 32'h2, 16'd200, 16'h0008, mb, 48'h0));
    send_header(make_header(16'h0806, 32'h1, 32'h2, 16'd200, 16'h0009, 48'h0,
                            48'hFFFF_FFFF_FFFF));
    send_header({48'h0000_0000_0000, 48'hFEFF_FFFF_FFFF, 16'hFFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF,
                 16'hFFFF, 32'h1234_5678, 32'h8765_4321, fsls_pkg::IPV4_TYPE});
    send_header(make_header(fsls_pkg::IPV4_TYPE, 32'h8765_4321, 32'h1234_5678, 16'd64,
                            16'h0010, 48'hFEFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF));
  endtask

  task automatic test_random_traffic(input int count);
    header_t h;
    repeat (count) begin
      h = make_header(($urandom_range(6) == 0) ? 16'($urandom) : fsls_pkg::IPV4_TYPE,
                      pick_ip(), pick_ip(), 16'($urandom), 16'($urandom),
                      pick_mac(), pick_mac());
      send_header(h);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    hold_len = 400;
    test_random_traffic(20);
  endtask

  task automatic test_table_full();
    header_t h;
    for (int i = 0; i < 270; i++) begin
      h = make_header(fsls_pkg::IPV4_TYPE, 32'hC0A8_0000 + i, 32'h0A0B_0000 + i,
                      16'($urandom), 16'(i), {8'h02, 8'hAA, 32'(i)}, pick_mac());
      send_header(h);
    end
  endtask

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    rst_ni = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    hold_len = 0;
    mismatches = 0;
    failures = 0;
    for (int i = 0; i < fsls_pkg::FLOW_ENTRIES; i++) fl_valid[i] = 1'b0;
    for (int i = 0; i < fsls_pkg::MAC_ENTRIES; i++) mc_valid[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      ip_pool[i] = $urandom;
      mac_pool[i] = 48'({$urandom, $urandom}) & 48'hFEFF_FFFF_FFFF;
    end
    mac_pool[15][fsls_pkg::GROUP_BIT] = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic(480);
    test_backpressure();
    test_table_full();
    test_random_traffic(100);
    idle_en = 1'b0;
    test_random_traffic(100);
    s_axis_tvalid_i = 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_verdicts.size() != 0) failures++;
    if (mismatches == 0 && failures == 0) begin
      $display("** flow_stats_learning_switch_top: PASSED **");
    end else begin
      $display("** flow_stats_learning_switch_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** flow_stats_learning_switch_top: FAILED **");
    $finish;
  end

endmodule
